### rtl/sliding_window_maximum_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window maximum block
// Each macro checks one property clocked on i_clk with reset masked.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg
// Types and fixed constants of the sliding window maximum block.
// ---------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int POS_W      = 16;
    localparam int CFG_W      = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index taken from the word address bit
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd1;

    // flips the sign bit so that an unsigned compare orders signed values
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RET_RD,
        ST_RET_CHK,
        ST_DROP_RD,
        ST_DROP_CHK,
        ST_APPEND,
        ST_MAX_RD,
        ST_MAX_CHK
    } t_state;

endpackage

### rtl/sliding_window_maximum.sv
// ---------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum over the last window_size samples of a row.
//
// Usage:
//  - Samples enter on the s_axis channel: tdata is the signed sample, tuser
//    flags the first sample of a new row, which empties the window.
//  - One result per sample leaves on m_axis: tdata is the window maximum,
//    tuser is set once window_size samples of the row have arrived.
//  - window_size sits at APB byte address 0 (1..64, 0 acts as 1, values
//    above WINDOW_MAX act as WINDOW_MAX). Write it only while idle.
//  - The queue of (value, position) pairs lives in one RAM and is worked
//    on by a single comparator under a sequencer, one RAM read per check.
//  - Per sample the sequencer steps through the ageing checks (a read, then
//    a check, per entry at the head), the drop checks (a read, then a check,
//    per entry at the tail), the append, and a final read and check of the
//    maximum. The result beat is offered in the cycle s_axis_tready returns
//    high.
//  - s_axis_tready is high only while the sequencer is idle; the result
//    register lets the next sample in while a result still waits.
//  - A stalled receiver holds the sequencer at its last step until the
//    result register frees up.
//  - Reset (synchronous, active low) empties the queue and sets
//    window_size to 1; RAM contents are not cleared.
// ---------------------------------------------------------------------------
`include "sliding_window_maximum_assert.svh"

module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [31:0] sample
    input  logic [0:0]            s_axis_tuser,   // [0] row_start
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [31:0] window_max
    output logic [0:0]            m_axis_tuser,   // [0] window_full
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int WW    = $clog2(WINDOW_MAX + 1);
    localparam int WSW   = (WW > CFG_W) ? WW : CFG_W;
    localparam int ENT_W = SAMPLE_W + POS_W;

    // configuration register
    logic [CFG_W-1:0] r_window_size;
    logic             apb_wr;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ?
                    APB_DATA_W'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RST;
        end else if (apb_wr && (paddr[2] == REG_WINDOW_SIZE)) begin
            r_window_size <= pwdata[CFG_W-1:0];
        end
    end

    // effective window, clamped to 1..WINDOW_MAX
    logic [WSW-1:0] ws_wide;
    logic [WW-1:0]  eff_win;

    assign ws_wide = WSW'(r_window_size);

    always_comb begin
        if (ws_wide == '0) begin
            eff_win = WW'(1);
        end else if (ws_wide > WSW'(WINDOW_MAX)) begin
            eff_win = WW'(WINDOW_MAX);
        end else begin
            eff_win = ws_wide[WW-1:0];
        end
    end

    // state and datapath registers
    t_state              r_state, n_state;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [WW-1:0]       r_win, n_win;
    logic [AW-1:0]       r_head, n_head;
    logic [WW-1:0]       r_count, n_count;
    logic [POS_W-1:0]    r_rowpos, n_rowpos;
    logic [WW-1:0]       r_samples, n_samples;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_max, n_out_max;
    logic                r_out_full, n_out_full;

    // RAM interface
    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [ENT_W-1:0] ram_rd_data;
    logic [SAMPLE_W-1:0] rd_val;
    logic [POS_W-1:0]    rd_pos;

    assign rd_val = ram_rd_data[SAMPLE_W-1:0];
    assign rd_pos = ram_rd_data[ENT_W-1:SAMPLE_W];

    // ring index: head plus an offset, wrapped once
    logic [WW-1:0] ring_off;
    logic [WW:0]   ring_sum;
    logic [AW-1:0] ring_idx;

    assign ring_off = (r_state == ST_APPEND) ? r_count : (r_count - WW'(1));
    assign ring_sum = (WW + 1)'(r_head) + (WW + 1)'(ring_off);
    assign ring_idx = (ring_sum >= (WW + 1)'(WINDOW_MAX)) ?
                      AW'(ring_sum - (WW + 1)'(WINDOW_MAX)) : AW'(ring_sum);

    // shared comparator: age against window, or sample against queued value
    logic [POS_W-1:0]    age;
    logic [SAMPLE_W-1:0] cmp_a, cmp_b;
    logic                cmp_lt;

    assign age = r_rowpos - rd_pos;

    always_comb begin
        if (r_state == ST_RET_CHK) begin
            cmp_a = SAMPLE_W'(age);
            cmp_b = SAMPLE_W'(r_win);
        end else begin
            cmp_a = r_sample ^ SIGN_FLIP;
            cmp_b = rd_val ^ SIGN_FLIP;
        end
    end

    assign cmp_lt = cmp_a < cmp_b;

    logic in_beat, out_free;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = ST_RET_RD;
                end
            end
            ST_RET_RD: begin
                n_state = (r_count != '0) ? ST_RET_CHK : ST_DROP_RD;
            end
            ST_RET_CHK: begin
                n_state = cmp_lt ? ST_DROP_RD : ST_RET_RD;
            end
            ST_DROP_RD: begin
                n_state = (r_count != '0) ? ST_DROP_CHK : ST_APPEND;
            end
            ST_DROP_CHK: begin
                n_state = cmp_lt ? ST_APPEND : ST_DROP_RD;
            end
            ST_APPEND: begin
                n_state = ST_MAX_RD;
            end
            ST_MAX_RD: begin
                n_state = ST_MAX_CHK;
            end
            ST_MAX_CHK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_sample    = r_sample;
        n_win       = r_win;
        n_head      = r_head;
        n_count     = r_count;
        n_rowpos    = r_rowpos;
        n_samples   = r_samples;
        n_out_max   = r_out_max;
        n_out_full  = r_out_full;
        n_out_valid = r_out_valid && !m_axis_tready;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_head;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_sample = s_axis_tdata;
                    n_win    = eff_win;
                    if (s_axis_tuser[0]) begin
                        n_head    = '0;
                        n_count   = '0;
                        n_rowpos  = '0;
                        n_samples = '0;
                    end
                end
            end
            ST_RET_RD: begin
                ram_rd_en = (r_count != '0);
            end
            ST_RET_CHK: begin
                // entry aged out: retire the head
                if (!cmp_lt) begin
                    n_head  = (r_head == AW'(WINDOW_MAX - 1)) ? '0 : r_head + AW'(1);
                    n_count = r_count - WW'(1);
                end
            end
            ST_DROP_RD: begin
                ram_rd_en   = (r_count != '0);
                ram_rd_addr = ring_idx;
            end
            ST_DROP_CHK: begin
                // queued value not greater than the sample: drop the tail
                if (!cmp_lt) begin
                    n_count = r_count - WW'(1);
                end
            end
            ST_APPEND: begin
                if (r_count < WW'(WINDOW_MAX)) begin
                    ram_wr_en = 1'b1;
                    n_count   = r_count + WW'(1);
                end
                if (r_samples < WW'(WINDOW_MAX)) begin
                    n_samples = r_samples + WW'(1);
                end
                n_rowpos = r_rowpos + POS_W'(1);
            end
            ST_MAX_RD: begin
                ram_rd_en = 1'b1;
            end
            ST_MAX_CHK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_max   = rd_val;
                    n_out_full  = (r_samples >= r_win);
                end
            end
            default: begin
                n_out_valid = r_out_valid && !m_axis_tready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rowpos    <= '0;
            r_samples   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rowpos    <= n_rowpos;
            r_samples   <= n_samples;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_win      <= n_win;
        r_out_max  <= n_out_max;
        r_out_full <= n_out_full;
    end

    // queue storage: position above value
    swm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_MAX)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ring_idx),
        .i_wr_data ({r_rowpos, r_sample}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign s_axis_tready   = (r_state == ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_max;
    assign m_axis_tuser[0] = r_out_full;

    // checks
    `SWM_ASSERT_NOW(a_count_bound, 1'b1, r_count <= WW'(WINDOW_MAX),
        "queue count above depth")
    `SWM_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_axis_tready,
        "sample taken while busy")
    `SWM_ASSERT_NOW(a_result_source, $rose(r_out_valid), $past(r_state == ST_MAX_CHK),
        "result raised outside final step")
    `SWM_ASSERT_NEXT(a_row_clear, in_beat && s_axis_tuser[0],
        (r_count == '0) && (r_rowpos == '0) && (r_samples == '0),
        "row start did not empty queue")
    `SWM_ASSERT_NEXT(a_append_grows, (r_state == ST_APPEND) && (r_count < WW'(WINDOW_MAX)),
        r_count == $past(r_count) + WW'(1), "append did not grow queue")

endmodule

### rtl/swm_ram.sv
// ---------------------------------------------------------------------------
// swm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### test/window_max_scoreboard_pkg.sv
// ---------------------------------------------------------------------------
// window_max_scoreboard_pkg
// Tracks the monotonic queue of the sliding window maximum, predicts one
// (window_max, window_full) beat per accepted sample and checks the beats
// that leave the block in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

package window_max_scoreboard_pkg;

    import swm_pkg::*;

    localparam int WIN_DEPTH = 64;

    typedef struct {
        logic [SAMPLE_W-1:0] window_max;
        logic                window_full;
    } t_max_beat;

    class window_max_scoreboard;

        // predicted queue of (value, position) pairs for the current row
        logic [SAMPLE_W-1:0] held_val [WIN_DEPTH];
        logic [POS_W-1:0]    held_pos [WIN_DEPTH];
        int unsigned         front;
        int unsigned         used;
        logic [POS_W-1:0]    next_pos;
        int unsigned         row_fill;
        logic [CFG_W-1:0]    win_setting;

        t_max_beat           expected_max_q [$];
        int                  mismatches;

        function new();
            front       = 0;
            used        = 0;
            next_pos    = '0;
            row_fill    = 0;
            win_setting = WINDOW_SIZE_RST;
            mismatches  = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] value);
            win_setting = value;
        endfunction

        function int pending();
            return expected_max_q.size();
        endfunction

        function void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected 0x%08h, got 0x%08h", what, want, got);
        endfunction

        // accepted sample: update the queue and predict its beat
        function void take_sample(logic [SAMPLE_W-1:0] sample, logic row_start);
            int unsigned      span;
            logic [POS_W-1:0] age;
            int unsigned      tail;
            t_max_beat        beat;

            // zero acts as one, oversized windows clamp to the depth
            span = (win_setting == 0) ? 1 :
                   (win_setting > WIN_DEPTH) ? WIN_DEPTH : win_setting;

            if (row_start) begin
                used     = 0;
                front    = 0;
                next_pos = '0;
                row_fill = 0;
            end

            // retire aged-out entries at the head, age taken modulo 2^16
            while (used > 0) begin
                age = next_pos - held_pos[front];
                if (age < span)
                    break;
                front = (front + 1) % WIN_DEPTH;
                used--;
            end

            // drop tail entries not greater than the new sample
            while (used > 0) begin
                tail = (front + used - 1) % WIN_DEPTH;
                if ($signed(held_val[tail]) > $signed(sample))
                    break;
                used--;
            end

            if (used < WIN_DEPTH) begin
                tail           = (front + used) % WIN_DEPTH;
                held_val[tail] = sample;
                held_pos[tail] = next_pos;
                used++;
            end

            if (row_fill < WIN_DEPTH)
                row_fill++;
            next_pos = next_pos + 1'b1;

            beat.window_max  = held_val[front];
            beat.window_full = (row_fill >= span);
            expected_max_q.insert(expected_max_q.size(), beat);
        endfunction

        // result beat: compare with the oldest prediction
        function void check_beat(logic [SAMPLE_W-1:0] window_max, logic window_full);
            t_max_beat want;

            if (expected_max_q.size() == 0) begin
                note_mismatch("unexpected result beat", '0, window_max);
                return;
            end
            want = expected_max_q[0];
            expected_max_q.delete(0);
            if (want.window_max !== window_max)
                note_mismatch("window_max", want.window_max, window_max);
            if (want.window_full !== window_full)
                note_mismatch("window_full", 32'(want.window_full), 32'(window_full));
        endfunction

    endclass

endpackage

### test/tb_sliding_window_maximum.sv
// ---------------------------------------------------------------------------
// tb_sliding_window_maximum
// Drives samples into the sliding window maximum under random backpressure
// and gaps, rewrites window_size between phases over APB, and checks every
// result beat against a scoreboard that mirrors the monotonic queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sliding_window_maximum;

    import swm_pkg::*;
    import window_max_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 160;      // worst sample: full queue dropped
    localparam int LONG_HOLD   = 400;
    localparam int LEAD_ITEMS  = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;    // [31:0] sample
    logic [0:0]            s_axis_tuser;    // [0] row_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;    // [31:0] window_max
    logic [0:0]            m_axis_tuser;    // [0] window_full
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    window_max_scoreboard  sb;
    int                    cycles = 0;

    // pacing and row shaping shared by the stimulus tasks
    int                    send_pace = 0;
    int                    sink_pace = 0;
    bit                    calm = 1'b0;
    bit                    long_hold_req = 1'b0;
    int                    row_left = 0;
    int                    value_mode = 0;
    logic [31:0]           ramp_val = '0;
    logic [CFG_W-1:0]      phase_win [8] = '{7'd2, 7'd64, 7'd1, 7'd65,
                                             7'd7, 7'd127, 7'd0, 7'd16};

    sliding_window_maximum #(
        .WINDOW_MAX (WIN_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result beats are checked at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser[0]);
    end

    // receiver pacing: random stall bursts, one long hold on request
    initial begin : sink_pacing
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                if (long_hold_req) begin
                    stall_left    = LONG_HOLD;
                    long_hold_req = 1'b0;
                end else if (!calm && sink_pace != 0 &&
                             $urandom_range(0, (sink_pace == 1) ? 7 : 2) == 0) begin
                    stall_left = $urandom_range(1, 13);
                end
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one sample beat; starts and ends on a falling edge, tvalid left high
    task automatic send_sample(input logic [31:0] value, input logic row_start);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= row_start;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_sample(value, row_start);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // sender pauses until every result is back and the sequencer has settled
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // APB write of window_size followed by a read-back
    task automatic write_window(input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_window(value);
        if (readback[CFG_W-1:0] !== value)
            sb.note_mismatch("window_size read-back", 32'(value), readback);
    endtask

    function automatic logic [31:0] pick_value();
        case (value_mode)
            0: return $urandom;
            1: return $urandom_range(0, 8) - 4;          // many equal values
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            3: begin                                      // falling run fills the queue
                ramp_val = ramp_val - $urandom_range(0, 3);
                return ramp_val;
            end
            default: begin                                // rising run drops each entry
                ramp_val = ramp_val + $urandom_range(0, 3);
                return ramp_val;
            end
        endcase
    endfunction

    // random rows with random content; with_rows clear keeps the current row
    task automatic feed_random(input int n, input bit with_rows);
        logic rs;
        repeat (n) begin
            rs = 1'b0;
            if (with_rows) begin
                if (row_left == 0) begin
                    rs         = 1'b1;
                    row_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                              : $urandom_range(5, 160);
                    value_mode = $urandom_range(0, 4);
                    ramp_val   = $urandom;
                end else begin
                    rs = ($urandom_range(0, 39) == 0);
                end
                row_left--;
            end
            if (!calm && send_pace != 0 &&
                $urandom_range(0, (send_pace == 1) ? 7 : 2) == 0)
                idle_sender($urandom_range(1, 13));
            send_sample(pick_value(), rs);
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        sb            = new();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset window of one: each beat is the sample itself
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);

        // window of three: equal values, extremes, rising run, row restart
        wait_idle();
        write_window(7'd3);
        send_sample(32'd5, 1'b1);
        send_sample(32'd5, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd10, 1'b1);
        send_sample(-32'sd7, 1'b0);

        // zero window acts as one
        wait_idle();
        write_window(7'd0);
        send_sample(32'd4, 1'b1);
        send_sample(32'd9, 1'b0);
        send_sample(-32'sd3, 1'b0);

        // oversized window clamps to the depth
        wait_idle();
        write_window(7'd127);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'd100, 1'b0);

        // random phases over several windows; phase 1 carries the long hold
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_window(phase_win[p]);
            send_pace = $urandom_range(0, 2);
            sink_pace = $urandom_range(0, 2);
            if (p == 1) begin
                send_pace     = 0;
                long_hold_req = 1'b1;
            end
            feed_random(80, 1'b1);
        end

        // a short row with window one, then a falling run in the same row
        // with a wider window set mid-row
        wait_idle();
        write_window(7'd1);
        send_pace = 0;
        sink_pace = 0;
        for (int k = 0; k < LEAD_ITEMS; k++)
            send_sample($urandom, k == 0);
        wait_idle();
        write_window(7'd6);
        send_pace  = 1;
        sink_pace  = 1;
        value_mode = 3;
        ramp_val   = $urandom;
        feed_random(120, 1'b0);

        // last stretch at full rate on both sides
        wait_idle();
        write_window(7'($urandom_range(1, 64)));
        calm      = 1'b1;
        send_pace = 0;
        feed_random(150, 1'b1);

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
